>>> sv/wrhu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the water ripple height map update block.
// No dependencies.
package wrhu_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// internal coordinate width, holds sizes up to 2047
	localparam int CW = 11;

	localparam int REFR_ONE   = 1024;
	localparam int REFR_SHIFT = 10;
	localparam int DIST_PEAK  = 9;

	localparam int WIDTH_RST = 256;
	localparam int HEIGHT_RST = 256;
	localparam int DAMP_RST  = 4;

	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_DISTURB = 2'd1,
		KIND_FRAME   = 2'd2,
		KIND_PIXEL   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_DAMP   = 2'd2
	} cfg_idx_t;

endpackage

>>> sv/wrhu_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wrhu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/water_ripple_heightmap_update.sv
`timescale 1ns / 1ps
// Water ripple height map update: two height maps, background image, sequencer.
// Depends on wrhu_pkg and wrhu_ram.
//
//  channel | signals                                         | moves
//  --------+-------------------------------------------------+-----------------
//  in      | in_valid, in_stall, kind, pos_x, pos_y,         | one item word
//          | ripple_radius, pixel_in                         |
//  out     | out_valid, out_stall, out_x, out_y, pixel_out,  | one result word
//          | pixel_written, frame_runs                       |
//  cfg     | cfg_we, cfg_index, cfg_data                     | register write
//
// One item at a time. Load, frame start and an out-of-area pixel update go
// straight to the result. A pixel update makes four neighbor reads through the
// single read port of the old map, then arithmetic, write back and background
// read (the last two only on a change); a disturbance visits (2r+1)^2 cells.
// After reset both maps are cleared one entry a cycle, 2^(XW+YW) entries
// (65536 at the default size); in_stall stays high meanwhile.
// A result waits in the output register while out_stall is high.
module water_ripple_heightmap_update #(
	parameter int MAX_WIDTH  = wrhu_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = wrhu_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [1:0]  ripple_radius,
	input  logic [31:0] pixel_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_x,
	output logic [7:0]  out_y,
	output logic [31:0] pixel_out,
	output logic        pixel_written,
	output logic        frame_runs,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int CW    = wrhu_pkg::CW;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DIST, ST_RD, ST_AVG, ST_SAT, ST_WR, ST_BG, ST_OUT, ST_DONE
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx, input logic [CW-1:0] cy);
		return {cy[YW-1:0], cx[XW-1:0]};
	endfunction

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic sel_q, dirty_q;
	logic [8:0] width_q, height_q;
	logic [3:0] damp_q;

	logic [7:0] x_q, y_q;
	logic [1:0] rad_q;
	logic signed [2:0] di_q, dj_q;
	logic [2:0] rd_cnt_q;
	logic signed [17:0] sum_q, avg1_q;
	logic signed [15:0] ctr_q, sat_q;
	logic changed_q, refr_q;
	logic [18:0] prod_x_q, prod_y_q;

	logic [31:0] res_pix_q;
	logic res_wr_q, res_run_q;
	logic out_valid_q;
	logic [7:0] out_x_q, out_y_q;
	logic [31:0] out_pix_q;
	logic out_wr_q, out_run_q;

	logic [CW-1:0] act_w, act_h;
	logic [CW-1:0] xi, yi, up_y, dn_y, lf_x, rt_x, tx, ty;
	logic in_acc;
	logic signed [17:0] avg2;
	logic signed [15:0] sat;
	logic [10:0] kf;
	logic [8:0] vx, vy;
	logic signed [CW:0] xx, yy;
	logic d_in;
	logic [1:0] adi, adj;
	logic [3:0] dval;

	logic cur_we, old_we;
	logic [AW-1:0] cur_waddr, old_waddr, cur_raddr, old_raddr;
	logic [15:0] cur_wdata, old_wdata, cur_rdata, old_rdata;
	logic a_we, b_we;
	logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
	logic [15:0] a_wdata, b_wdata, a_rdata, b_rdata;
	logic bg_we;
	logic [AW-1:0] bg_waddr, bg_raddr;
	logic [31:0] bg_rdata;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		if (width_q == 9'd0) act_w = CW'(1);
		else if ({2'b0, width_q} > CW'(MAX_WIDTH)) act_w = CW'(MAX_WIDTH);
		else act_w = {2'b0, width_q};
		if (height_q == 9'd0) act_h = CW'(1);
		else if ({2'b0, height_q} > CW'(MAX_HEIGHT)) act_h = CW'(MAX_HEIGHT);
		else act_h = {2'b0, height_q};
	end

	assign xi   = {3'b0, x_q};
	assign yi   = {3'b0, y_q};
	assign up_y = (yi == '0) ? yi : yi - CW'(1);
	assign dn_y = (yi >= act_h - CW'(1)) ? yi : yi + CW'(1);
	assign lf_x = (xi == '0) ? xi : xi - CW'(1);
	assign rt_x = (xi >= act_w - CW'(1)) ? xi : xi + CW'(1);

	// damping and saturation
	assign avg2 = avg1_q - ((damp_q == 4'd0) ? avg1_q : (avg1_q >>> damp_q));
	assign sat  = (avg2 > 18'sd32767) ? 16'sh7fff :
	              (avg2 < -18'sd32768) ? 16'sh8000 : avg2[15:0];

	// refraction
	assign kf = 11'(wrhu_pkg::REFR_ONE) - sat_q[10:0];
	assign vx = prod_x_q[18:wrhu_pkg::REFR_SHIFT];
	assign vy = prod_y_q[18:wrhu_pkg::REFR_SHIFT];
	always_comb begin
		tx = xi;
		ty = yi;
		if (refr_q) begin
			if (vx == 9'd0) tx = '0;
			else if ({2'b0, vx} >= act_w) tx = act_w - CW'(1);
			else tx = {2'b0, vx};
			if (vy == 9'd0) ty = '0;
			else if ({2'b0, vy} >= act_h) ty = act_h - CW'(1);
			else ty = {2'b0, vy};
		end
	end

	// disturbance cell
	assign xx   = $signed({1'b0, xi}) + (CW+1)'(di_q);
	assign yy   = $signed({1'b0, yi}) + (CW+1)'(dj_q);
	assign d_in = !xx[CW] && !yy[CW] && (xx[CW-1:0] < act_w) && (yy[CW-1:0] < act_h);
	assign adi  = di_q[2] ? 2'(-di_q) : di_q[1:0];
	assign adj  = dj_q[2] ? 2'(-dj_q) : dj_q[1:0];
	assign dval = 4'(wrhu_pkg::DIST_PEAK) - {2'b0, adi} - {2'b0, adj};

	always_comb begin
		cur_we    = (state_q == ST_WR) && changed_q;
		cur_waddr = cell_addr(xi, yi);
		cur_wdata = sat_q;
		cur_raddr = cell_addr(xi, yi);
		old_we    = (state_q == ST_DIST) && d_in;
		old_waddr = cell_addr(xx[CW-1:0], yy[CW-1:0]);
		old_wdata = 16'(1) << dval;
		case (rd_cnt_q)
			3'd0: old_raddr = cell_addr(xi, up_y);
			3'd1: old_raddr = cell_addr(xi, dn_y);
			3'd2: old_raddr = cell_addr(lf_x, yi);
			default: old_raddr = cell_addr(rt_x, yi);
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			a_we = 1'b1; a_waddr = clr_q; a_wdata = '0;
			b_we = 1'b1; b_waddr = clr_q; b_wdata = '0;
		end else if (sel_q) begin
			b_we = cur_we; b_waddr = cur_waddr; b_wdata = cur_wdata;
			a_we = old_we; a_waddr = old_waddr; a_wdata = old_wdata;
		end else begin
			a_we = cur_we; a_waddr = cur_waddr; a_wdata = cur_wdata;
			b_we = old_we; b_waddr = old_waddr; b_wdata = old_wdata;
		end
		a_raddr   = sel_q ? old_raddr : cur_raddr;
		b_raddr   = sel_q ? cur_raddr : old_raddr;
		cur_rdata = sel_q ? b_rdata : a_rdata;
		old_rdata = sel_q ? a_rdata : b_rdata;
	end

	assign bg_we    = in_acc && (wrhu_pkg::kind_t'(kind) == wrhu_pkg::KIND_LOAD)
	                  && ({3'b0, pos_x} < CW'(MAX_WIDTH)) && ({3'b0, pos_y} < CW'(MAX_HEIGHT));
	assign bg_waddr = cell_addr({3'b0, pos_x}, {3'b0, pos_y});
	assign bg_raddr = cell_addr(tx, ty);

	wrhu_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_map_a (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata)
	);
	wrhu_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_map_b (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata)
	);
	wrhu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_bg (
		.clk(clk), .we(bg_we), .waddr(bg_waddr), .wdata(pixel_in), .raddr(bg_raddr),
		.rdata(bg_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'(wrhu_pkg::WIDTH_RST);
			height_q <= 9'(wrhu_pkg::HEIGHT_RST);
			damp_q   <= 4'(wrhu_pkg::DAMP_RST);
		end else if (cfg_we) begin
			case (wrhu_pkg::cfg_idx_t'(cfg_index))
				wrhu_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				wrhu_pkg::CFG_HEIGHT: height_q <= cfg_data;
				wrhu_pkg::CFG_DAMP:   damp_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sel_q       <= 1'b0;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			rd_cnt_q    <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						x_q       <= pos_x;
						y_q       <= pos_y;
						rad_q     <= ripple_radius;
						di_q      <= -$signed({1'b0, ripple_radius});
						dj_q      <= -$signed({1'b0, ripple_radius});
						rd_cnt_q  <= '0;
						res_pix_q <= '0;
						res_wr_q  <= 1'b0;
						res_run_q <= (wrhu_pkg::kind_t'(kind) == wrhu_pkg::KIND_FRAME) && dirty_q;
						case (wrhu_pkg::kind_t'(kind))
							wrhu_pkg::KIND_DISTURB: state_q <= ST_DIST;
							wrhu_pkg::KIND_FRAME: begin
								if (dirty_q) begin
									sel_q   <= ~sel_q;
									dirty_q <= 1'b0;
								end
								state_q <= ST_DONE;
							end
							wrhu_pkg::KIND_PIXEL: begin
								if ({3'b0, pos_x} >= act_w || {3'b0, pos_y} >= act_h)
									state_q <= ST_DONE;
								else
									state_q <= ST_RD;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_DIST: begin
					if (di_q == $signed({1'b0, rad_q})) begin
						di_q <= -$signed({1'b0, rad_q});
						if (dj_q == $signed({1'b0, rad_q})) begin
							dirty_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							dj_q <= dj_q + 3'sd1;
						end
					end else begin
						di_q <= di_q + 3'sd1;
					end
				end
				ST_RD: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd0) sum_q <= '0;
					else sum_q <= sum_q + 18'($signed(old_rdata));
					if (rd_cnt_q == 3'd1) ctr_q <= cur_rdata;
					if (rd_cnt_q == 3'd4) state_q <= ST_AVG;
				end
				ST_AVG: begin
					avg1_q  <= (sum_q >>> 1) - 18'(ctr_q);
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					sat_q     <= sat;
					changed_q <= (sat != ctr_q);
					state_q   <= ST_WR;
				end
				ST_WR: begin
					refr_q   <= (sat_q > 16'sd0) && (sat_q < 16'(wrhu_pkg::REFR_ONE));
					prod_x_q <= x_q * kf;
					prod_y_q <= y_q * kf;
					if (changed_q) begin
						dirty_q <= 1'b1;
						state_q <= ST_BG;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_BG: state_q <= ST_OUT;
				ST_OUT: begin
					res_pix_q <= bg_rdata;
					res_wr_q  <= 1'b1;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_x_q     <= x_q;
						out_y_q     <= y_q;
						out_pix_q   <= res_pix_q;
						out_wr_q    <= res_wr_q;
						out_run_q   <= res_run_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_x         = out_x_q;
	assign out_y         = out_y_q;
	assign pixel_out     = out_pix_q;
	assign pixel_written = out_wr_q;
	assign frame_runs    = out_run_q;

endmodule

>>> tb/sv/water_ripple_heightmap_update_tb.sv
`timescale 1ns / 1ps
// Testbench for water_ripple_heightmap_update: random and directed item words,
// predicted results in a scoreboard class. Depends on wrhu_pkg and the block.
module water_ripple_heightmap_update_tb;

	localparam int ROWW = 256;
	localparam int REGION = 12;
	localparam int LIMIT = 1000000;

	typedef struct packed {
		logic [7:0]  x;
		logic [7:0]  y;
		logic [31:0] pix;
		logic        written;
		logic        runs;
	} ripple_res_t;

	class ripple_scoreboard;
		logic signed [15:0] hmap [2][ROWW*256];
		logic [31:0] bg [ROWW*256];
		bit loaded [ROWW*256];
		bit sel;
		bit dirty;
		int unsigned wreg, hreg, dshift;
		ripple_res_t pending_q [$];
		int errors;

		function void clear();
			foreach (hmap[m, c]) hmap[m][c] = '0;
			sel = 0;
			dirty = 0;
			wreg = 256;
			hreg = 256;
			dshift = 4;
			errors = 0;
		endfunction

		function int act_w();
			return wreg == 0 ? 1 : (wreg > 256 ? 256 : wreg);
		endfunction

		function int act_h();
			return hreg == 0 ? 1 : (hreg > 256 ? 256 : hreg);
		endfunction

		function void write_reg(wrhu_pkg::cfg_idx_t idx, logic [8:0] d);
			case (idx)
				wrhu_pkg::CFG_WIDTH: wreg = d;
				wrhu_pkg::CFG_HEIGHT: hreg = d;
				wrhu_pkg::CFG_DAMP: dshift = d[3:0];
				default: ;
			endcase
		endfunction

		function void note_item(wrhu_pkg::kind_t k, logic [7:0] px, logic [7:0] py,
				logic [1:0] rad, logic [31:0] pin);
			ripple_res_t r;
			int w, h, val, xx, yy, row, up, dn, lf, rt, old, avg, kk, rx, ry;
			w = act_w();
			h = act_h();
			r = '{x: px, y: py, pix: '0, written: 1'b0, runs: 1'b0};
			case (k)
				wrhu_pkg::KIND_LOAD: begin
					bg[{py, px}] = pin;
					loaded[{py, px}] = 1;
				end
				wrhu_pkg::KIND_DISTURB: begin
					for (int j = -int'(rad); j <= int'(rad); j++) begin
						val = 8 - int'(rad) - (j < 0 ? -j : j);
						yy = int'(py) + j;
						for (int i = -int'(rad); i <= int'(rad); i++) begin
							xx = int'(px) + i;
							val += (i <= 0) ? 1 : -1;
							if (yy >= 0 && yy < h && xx >= 0 && xx < w)
								hmap[~sel][yy*ROWW + xx] = 16'(1 << val);
						end
					end
					dirty = 1;
				end
				wrhu_pkg::KIND_FRAME: begin
					if (dirty) begin
						sel = ~sel;
						dirty = 0;
						r.runs = 1;
					end
				end
				default: begin
					if (px < w && py < h) begin
						row = py * ROWW;
						up = (py == 0) ? row : row - ROWW;
						dn = (py >= h - 1) ? row : row + ROWW;
						lf = (px == 0) ? px : px - 1;
						rt = (px >= w - 1) ? px : px + 1;
						old = hmap[sel][row + px];
						avg = ((int'(hmap[~sel][up + px]) + hmap[~sel][dn + px]
							+ hmap[~sel][row + lf] + hmap[~sel][row + rt]) >>> 1) - old;
						avg -= avg >>> dshift;
						if (avg > 32767) avg = 32767;
						if (avg < -32768) avg = -32768;
						if (avg != old) begin
							hmap[sel][row + px] = 16'(avg);
							dirty = 1;
							rx = px;
							ry = py;
							if (avg > 0 && avg < 1024) begin
								kk = 1024 - avg;
								rx = (int'(px) * kk) >> 10;
								ry = (int'(py) * kk) >> 10;
								rx = rx <= 0 ? 0 : (rx >= w ? w - 1 : rx);
								ry = ry <= 0 ? 0 : (ry >= h ? h - 1 : ry);
							end
							r.pix = bg[ry*ROWW + rx];
							r.written = 1;
						end
					end
				end
			endcase
			pending_q.push_back(r);
		endfunction

		function void check_result(ripple_res_t got);
			ripple_res_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected result word x=%0d y=%0d", got.x, got.y);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (got.x !== e.x) begin
				$error("out_x expected %0d got %0d", e.x, got.x); errors++;
			end
			if (got.y !== e.y) begin
				$error("out_y expected %0d got %0d", e.y, got.y); errors++;
			end
			if (got.pix !== e.pix) begin
				$error("pixel_out expected %h got %h", e.pix, got.pix); errors++;
			end
			if (got.written !== e.written) begin
				$error("pixel_written expected %0d got %0d", e.written, got.written);
				errors++;
			end
			if (got.runs !== e.runs) begin
				$error("frame_runs expected %0d got %0d", e.runs, got.runs); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic [7:0] pos_x = '0, pos_y = '0;
	logic [1:0] ripple_radius = '0;
	logic [31:0] pixel_in = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] out_x, out_y;
	logic [31:0] pixel_out;
	logic pixel_written, frame_runs;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;

	int unsigned send_idle_pct, stall_pct;
	int unsigned cycles = 0;
	ripple_scoreboard sb;

	water_ripple_heightmap_update uut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{x: out_x, y: out_y, pix: pixel_out,
				written: pixel_written, runs: frame_runs});

	task automatic send_word(wrhu_pkg::kind_t k, logic [7:0] px, logic [7:0] py,
			logic [1:0] rad, logic [31:0] pin);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		pos_x <= px;
		pos_y <= py;
		ripple_radius <= rad;
		pixel_in <= pin;
		do @(posedge clk); while (in_stall);
		sb.note_item(k, px, py, rad, pin);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(wrhu_pkg::cfg_idx_t idx, logic [8:0] d);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, d);
	endtask

	task automatic random_phase(int n);
		int rw, rh, w, h, sel_k;
		logic [7:0] px, py;
		w = sb.act_w();
		h = sb.act_h();
		rw = w < REGION ? w : REGION;
		rh = h < REGION ? h : REGION;
		for (int y = 0; y < rh; y++)
			for (int x = 0; x < rw; x++)
				if (!sb.loaded[y*ROWW + x])
					send_word(wrhu_pkg::KIND_LOAD, 8'(x), 8'(y), 2'd0, $urandom);
		for (int n_done = 0; n_done < n; n_done++) begin
			sel_k = $urandom_range(99);
			if (sel_k < 8) begin
				send_word(wrhu_pkg::KIND_LOAD, 8'($urandom), 8'($urandom), 2'($urandom),
					$urandom);
			end else if (sel_k < 20) begin
				px = 8'($urandom_range(0, $urandom_range(1) ? rw + 3 : 255));
				py = 8'($urandom_range(0, $urandom_range(1) ? rh + 3 : 255));
				send_word(wrhu_pkg::KIND_DISTURB, px, py, 2'($urandom), $urandom);
			end else if (sel_k < 32) begin
				send_word(wrhu_pkg::KIND_FRAME, 8'($urandom), 8'($urandom), 2'($urandom),
					$urandom);
			end else if (sel_k < 38 && (w < 256 || h < 256)) begin
				if (w < 256) begin
					px = 8'($urandom_range(w, 255)); py = 8'($urandom);
				end else begin
					px = 8'($urandom); py = 8'($urandom_range(h, 255));
				end
				send_word(wrhu_pkg::KIND_PIXEL, px, py, 2'($urandom), $urandom);
			end else begin
				send_word(wrhu_pkg::KIND_PIXEL, 8'($urandom_range(0, rw - 1)),
					8'($urandom_range(0, rh - 1)), 2'($urandom), $urandom);
			end
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_reg(wrhu_pkg::CFG_WIDTH, 12);
		write_reg(wrhu_pkg::CFG_HEIGHT, 12);
		write_reg(wrhu_pkg::CFG_DAMP, 4);
		random_phase(0);
		// directed: clean frame, loads, corner and edge disturbances, corners, outside
		send_word(wrhu_pkg::KIND_FRAME, 8'h00, 8'hff, 2'd3, 32'h0);
		send_word(wrhu_pkg::KIND_LOAD, 8'hff, 8'hff, 2'd0, 32'hffffffff);
		send_word(wrhu_pkg::KIND_LOAD, 8'h00, 8'h00, 2'd3, 32'h00000000);
		send_word(wrhu_pkg::KIND_DISTURB, 8'd0, 8'd0, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_DISTURB, 8'd11, 8'd11, 2'd3, 32'h0);
		send_word(wrhu_pkg::KIND_DISTURB, 8'd5, 8'd0, 2'd1, 32'h0);
		send_word(wrhu_pkg::KIND_DISTURB, 8'd0, 8'd6, 2'd2, 32'h0);
		send_word(wrhu_pkg::KIND_DISTURB, 8'd255, 8'd255, 2'd3, 32'h0);
		send_word(wrhu_pkg::KIND_FRAME, 8'd0, 8'd0, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_FRAME, 8'd0, 8'd0, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_PIXEL, 8'd0, 8'd0, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_PIXEL, 8'd11, 8'd11, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_PIXEL, 8'd11, 8'd0, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_PIXEL, 8'd0, 8'd11, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_PIXEL, 8'd1, 8'd1, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_PIXEL, 8'd12, 8'd3, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_PIXEL, 8'd255, 8'd255, 2'd0, 32'h0);
		send_word(wrhu_pkg::KIND_FRAME, 8'd0, 8'd0, 2'd0, 32'h0);
		random_phase(40);

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: begin write_reg(wrhu_pkg::CFG_WIDTH, 1); write_reg(wrhu_pkg::CFG_HEIGHT, 1);
					write_reg(wrhu_pkg::CFG_DAMP, 9); end
				1: begin write_reg(wrhu_pkg::CFG_WIDTH, 8); write_reg(wrhu_pkg::CFG_HEIGHT, 5);
					write_reg(wrhu_pkg::CFG_DAMP, 0); end
				2: begin write_reg(wrhu_pkg::CFG_WIDTH, 0);
					write_reg(wrhu_pkg::CFG_HEIGHT, 9'd511);
					write_reg(wrhu_pkg::CFG_DAMP, 15); end
				3: begin write_reg(wrhu_pkg::CFG_WIDTH, 256);
					write_reg(wrhu_pkg::CFG_HEIGHT, 256);
					write_reg(wrhu_pkg::CFG_DAMP, 5);
					write_reg(wrhu_pkg::cfg_idx_t'(2'd3), 9'h1ff); end
				default: begin write_reg(wrhu_pkg::CFG_WIDTH, 10);
					write_reg(wrhu_pkg::CFG_HEIGHT, 7);
					write_reg(wrhu_pkg::CFG_DAMP, 6); end
			endcase
			send_idle_pct = (ph % 4 == 0 || ph % 4 == 3) ? (ph % 4 == 0 ? 72 : 37) : 0;
			stall_pct = (ph % 4 == 1) ? 72 : (ph % 4 == 3 ? 37 : 0);
			random_phase(40);
		end
		send_idle_pct = 0;
		stall_pct = 0;
		drain();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

>>> sim.f
sv/wrhu_pkg.sv
sv/wrhu_ram.sv
sv/water_ripple_heightmap_update.sv
tb/sv/water_ripple_heightmap_update_tb.sv
